FILE: rtl/core/gpf_pkg.sv
// ----------------------------------------------------------------------------
// gpf_pkg
// shared types and sequencer codes for the greatest prime factor block
// ----------------------------------------------------------------------------
package gpf_pkg;

    typedef logic [1:0] state_t;

    localparam state_t S_IDLE = 2'd0;
    localparam state_t S_DIV  = 2'd1;
    localparam state_t S_EVAL = 2'd2;
    localparam state_t S_DONE = 2'd3;

endpackage

FILE: rtl/core/greatest_prime_factor_top.sv
// ----------------------------------------------------------------------------
// greatest_prime_factor_top
// greatest prime factor by trial division over one shared restoring divider
//
// channel  dir  signals                       word contents (low bit up)
// s_*      in   s_tvalid s_tready s_tdata     value [WIDTH-1:0], zero pad
// m_*      out  m_tvalid m_tready m_tdata     largest_factor [WIDTH-1:0], zero pad
//
// each trial division runs WIDTH shift/subtract steps on the shared divider,
// followed by the evaluate state; an item takes one trial division per trial
// divisor plus one per factor found, up to roughly 2^(WIDTH/2-1) trials for a
// large prime input
// s_tready is high only while the sequencer is idle; one word is in flight
// a finished word waits in the output register while the next word is taken
// reset is asynchronous, active low, and clears all control state
// ----------------------------------------------------------------------------
module greatest_prime_factor_top
    import gpf_pkg::*;
#(
    parameter int WIDTH = 32,
    localparam int TDATA_W = ((WIDTH + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // value
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // largest_factor
);

    localparam int CNT_W   = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);
    localparam logic [WIDTH-1:0] TWO   = WIDTH'(2);
    localparam logic [WIDTH-1:0] THREE = WIDTH'(3);

    state_t             state_reg, state_next;
    logic [WIDTH-1:0]   n_reg, n_next;
    logic [WIDTH-1:0]   d_reg, d_next;
    logic [WIDTH-1:0]   best_reg, best_next;
    logic [WIDTH-1:0]   rem_reg, rem_next;
    logic [WIDTH-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ovld_reg, ovld_next;
    logic [WIDTH-1:0]   odata_reg, odata_next;

    logic [WIDTH-1:0]   in_value;
    logic [WIDTH:0]     shifted;
    logic               fits;

    assign in_value = s_tdata[WIDTH-1:0];
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovld_reg;
    assign m_tdata  = TDATA_W'(odata_reg);

    // one restoring divide step
    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign fits    = (shifted >= {1'b0, d_reg});

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        best_next  = best_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        ovld_next  = ovld_reg;
        odata_next = odata_reg;

        if (ovld_reg && m_tready)
        begin
            ovld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    n_next = in_value;
                    if (in_value < TWO)
                    begin
                        best_next  = in_value;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        best_next  = WIDTH'(1);
                        d_next     = TWO;
                        rem_next   = '0;
                        quo_next   = in_value;
                        cnt_next   = CNT_LAST;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (fits)
                begin
                    rem_next = WIDTH'(shifted - {1'b0, d_reg});
                end
                else
                begin
                    rem_next = shifted[WIDTH-1:0];
                end
                quo_next = {quo_reg[WIDTH-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                // quo_reg = n / d, rem_reg = n % d
                if (d_reg > quo_reg)
                begin
                    // divisor squared passed the remaining value n
                    if (n_reg > WIDTH'(1))
                    begin
                        best_next = n_reg;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    cnt_next   = CNT_LAST;
                    state_next = S_DIV;
                    if (rem_reg == '0)
                    begin
                        // divide the factor out and retry the same divisor
                        best_next = d_reg;
                        n_next    = quo_reg;
                        quo_next  = quo_reg;
                    end
                    else
                    begin
                        d_next   = (d_reg == TWO) ? THREE : d_reg + TWO;
                        quo_next = n_reg;
                    end
                end
            end
            S_DONE:
            begin
                if (!ovld_reg || m_tready)
                begin
                    ovld_next  = 1'b1;
                    odata_next = best_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovld_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        best_reg  <= best_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        odata_reg <= odata_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while sequencer busy");

    a_divisor_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (d_reg >= TWO))
        else $error("trial divisor below two");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> (rem_reg < d_reg))
        else $error("divider remainder not below divisor");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovld_reg) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside done state");

endmodule

FILE: test/greatest_prime_factor_top_tb.sv
// ----------------------------------------------------------------------------
// greatest_prime_factor_top_tb
// self-checking bench for the greatest prime factor block
//
// values go in on the s_* stream and every accepted word is predicted by a
// trial division model kept in the bench; results on the m_* stream are
// checked in order against that model. both sides idle at random, the output
// is held off for a long stretch once so the block backs up, and the last
// part runs without any idling
// ----------------------------------------------------------------------------
module greatest_prime_factor_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH      = 32;
    localparam int TDATA_W    = ((WIDTH + 7) / 8) * 8;
    localparam int LONG_HOLD  = 400;
    localparam int QUIET_MAX  = 400000;
    localparam int TAIL_WAIT  = 200;

    typedef logic [WIDTH-1:0] word_t;

    typedef struct {
        word_t value;
        word_t factor;
    } factor_entry_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;   // value
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;        // largest_factor

    factor_entry_t pending_factors[$];
    bit            idle_on = 1'b1;
    bit            long_hold_req = 1'b0;
    int            stall_left = 0;
    int            quiet_cycles = 0;
    int            mismatches = 0;
    int            words_sent = 0;
    int            words_checked = 0;

    greatest_prime_factor_top #(
        .WIDTH(WIDTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #4 clk = ~clk;

    // greatest prime factor by trial division: 2, then odd divisors
    function automatic word_t greatest_factor(word_t value);
        longint unsigned rest;
        longint unsigned best;
        longint unsigned div;
        rest = value;
        best = 1;
        if (rest < 2)
        begin
            return value;
        end
        if (rest % 2 == 0)
        begin
            best = 2;
            while (rest % 2 == 0)
            begin
                rest = rest / 2;
            end
        end
        for (div = 3; div <= rest / div; div += 2)
        begin
            if (rest % div == 0)
            begin
                best = div;
                while (rest % div == 0)
                begin
                    rest = rest / div;
                end
            end
        end
        if (rest > 1)
        begin
            best = rest;
        end
        return word_t'(best);
    endfunction

    // offer one word and wait for the edge that takes it
    task automatic send_value(input word_t value);
        factor_entry_t entry;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(value);
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        entry.value  = value;
        entry.factor = greatest_factor(value);
        pending_factors.push_back(entry);
        words_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_factors.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed();
        word_t corner_values[$];
        corner_values = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd9,
            32'd1000003,                   // prime
            32'd16777213,                  // prime just under 2^24
            32'd4093 * 32'd1000003,        // two large prime factors
            32'd97 * 32'd97 * 32'd97,      // prime power
            32'd223092870,                 // product of the first nine primes
            32'h8000_0000,
            32'hFFFF_FFFF,
            32'hFFFF_FFFC,
            32'hAAAA_AAAA,
            32'h5555_5555
        };
        foreach (corner_values[i])
        begin
            send_value(corner_values[i]);
        end
        wait_drained();
    endtask

    // output held off while small values keep coming, so the input stalls
    task automatic test_backpressure();
        word_t quick_values[$];
        quick_values = '{32'd4, 32'd6, 32'd2, 32'd8, 32'd3, 32'd12};
        idle_on = 1'b0;
        long_hold_req = 1'b1;
        foreach (quick_values[i])
        begin
            send_value(quick_values[i]);
        end
        wait_drained();
        idle_on = 1'b1;
    endtask

    // mostly a smooth cofactor times a bounded random part, keeping trial counts modest
    task automatic test_random(input int count, input bit with_idle);
        longint unsigned product;
        longint unsigned mult;
        int              part_bits;
        bit              done;
        idle_on = with_idle;
        repeat (count)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                product = $urandom_range(0, 65535);
            end
            else
            begin
                part_bits = ($urandom_range(0, 19) == 0) ? 22 : $urandom_range(4, 16);
                product = $urandom_range(1, 1 << part_bits);
                done = 1'b0;
                while (!done)
                begin
                    mult = $urandom_range(2, 64);
                    if (product * mult > 64'hFFFF_FFFF)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        product = product * mult;
                        done = ($urandom_range(0, 9) == 0);
                    end
                end
            end
            send_value(word_t'(product));
        end
        wait_drained();
    endtask

    // receiver: random stall bursts plus one long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        factor_entry_t entry;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_factors.size() == 0)
            begin
                $error("unexpected result word: largest_factor %0d", m_tdata[WIDTH-1:0]);
                mismatches++;
            end
            else
            begin
                entry = pending_factors.pop_front();
                words_checked++;
                if (m_tdata[WIDTH-1:0] !== entry.factor)
                begin
                    $error("largest_factor of %0d: expected %0d, actual %0d",
                           entry.value, entry.factor, m_tdata[WIDTH-1:0]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else if (rst_n)
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("timeout after %0d quiet cycles, %0d words pending",
                         quiet_cycles, pending_factors.size());
                $display("greatest_prime_factor_top_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random(60, 1'b1);
        test_random(20, 1'b0);

        repeat (TAIL_WAIT) @(posedge clk);

        $display("sent %0d values, checked %0d factors", words_sent, words_checked);
        $display("edge values, primes, prime powers, long output stall, idle-free tail");
        if (mismatches == 0)
        begin
            $display("greatest_prime_factor_top_tb: clean");
        end
        else
        begin
            $display("greatest_prime_factor_top_tb: errors");
        end
        $finish;
    end

endmodule
